FILE: rtl/handle_multi_stack_defines.svh
// Assertion macros shared by the handle_multi_stack RTL.
`ifndef HANDLE_MULTI_STACK_DEFINES_SVH
`define HANDLE_MULTI_STACK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle_multi_stack: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle_multi_stack: next-cycle check failed");

`endif

FILE: rtl/hms_pkg.sv
// Shared codes, field widths and the result type of the handle stack block.
package hms_pkg;

    // Field widths of the request and result items.
    localparam int FUNC_BITS   = 3;
    localparam int ID_BITS     = 4;
    localparam int DWORD_BITS  = 32;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 7;

    // Request codes.
    localparam logic [FUNC_BITS-1:0] FUNC_CREATE  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH    = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_POP     = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_DESTROY = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_COUNT   = 3'd4;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NO_FREE = 3'd4;

    // One result item, packed so that status lands in the lowest bits.
    typedef struct packed {
        logic [COUNT_BITS-1:0]  elem_count;
        logic [DWORD_BITS-1:0]  pop_word;
        logic [ID_BITS-1:0]     result_id;
        logic [STATUS_BITS-1:0] status;
    } result_t;

endpackage

FILE: rtl/hms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/handle_multi_stack.sv
// Top level of the handle stack block: request sequencer, state memories and output stage.
`include "handle_multi_stack_defines.svh"

// A set of NUM_STACKS last-in first-out stacks named by handles 1 to NUM_STACKS, each holding up
// to STACK_DEPTH words. One request is worked on at a time and gives exactly one result item.
// The per-stack element counts sit in a small RAM and the elements in a second RAM, both with a
// registered read; the in-use flags are flip-flops and also mark which count entries hold data.
// A bad handle or unknown request goes straight to the result; push, destroy and count read the
// count, and push (unless full) and destroy then update it; pop reads the count, then (unless
// empty) the element; create scans the handles from the lowest (one per cycle) until a free one
// is found or none is left. A finished result waits in the output register while the next item
// is accepted; if that register is still full when a new result is ready, the sequencer holds
// until the result side takes the waiting item. No clearing pass is needed after reset.
module handle_multi_stack
    import hms_pkg::*;
#(
    parameter int NUM_STACKS  = 8,
    parameter int STACK_DEPTH = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[2:0], stack_id[6:3], push_word[38:7], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], result_id[6:3], pop_word[38:7],
                                   // elem_count[45:39], zero fill
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int ED = NUM_STACKS * STACK_DEPTH;
    localparam int AW = (ED > 1) ? $clog2(ED) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [NUM_STACKS-1:0] in_use_reg, in_use_next;
    logic [SW-1:0]         scan_reg, scan_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic [FUNC_BITS-1:0]  func_reg, func_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [DWORD_BITS-1:0] word_reg, word_next;
    result_t               res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               m_data_reg, m_data_next;

    // Request fields.
    logic [FUNC_BITS-1:0]  in_func;
    logic [ID_BITS-1:0]    in_id;
    logic [DWORD_BITS-1:0] in_word;
    logic [8:0]            in_id_m1;
    logic [SW-1:0]         in_idx;
    logic                  in_id_ok;
    logic                  in_used;
    logic                  accept;

    // Memory ports.
    logic          fill_we;
    logic [SW-1:0] fill_waddr;
    logic [CW-1:0] fill_wdata;
    logic [CW-1:0] fill_rdata;
    logic [CW-1:0] fill_dec;
    logic                 elem_we;
    logic [AW-1:0]        elem_waddr;
    logic [WORD_BITS-1:0] elem_wdata;
    logic [AW-1:0]        elem_raddr;
    logic [WORD_BITS-1:0] elem_rdata;
    logic [AW-1:0]        base_addr;
    logic [63:0]          push_ext;
    logic [63:0]          pop_ext;
    logic                 out_free;

    assign in_func  = s_tdata[2:0];
    assign in_id    = s_tdata[6:3];
    assign in_word  = s_tdata[38:7];
    assign in_id_m1 = {5'd0, in_id} - 9'd1;
    assign in_idx   = in_id_m1[SW-1:0];
    assign in_id_ok = (in_id != '0) && ({23'd0, in_id} <= 27'(NUM_STACKS));
    assign in_used  = in_id_ok ? in_use_reg[in_idx] : 1'b0;
    assign accept   = s_tvalid && s_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // Address arithmetic for the addressed stack.
    assign base_addr  = AW'(idx_reg) * AW'(STACK_DEPTH);
    assign fill_dec   = fill_rdata - CW'(1);
    assign push_ext   = 64'(word_reg);
    assign pop_ext    = 64'(elem_rdata);
    assign elem_waddr = base_addr + AW'(fill_rdata);
    assign elem_raddr = base_addr + AW'(fill_dec);
    assign elem_wdata = push_ext[WORD_BITS-1:0];

    // Element counts, one entry per handle; valid only while the handle is in use.
    hms_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_STACKS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (in_idx),
        .rdata (fill_rdata)
    );

    // Element storage, STACK_DEPTH words per handle.
    hms_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ED)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    // Request sequencer. The next request is taken only after this one has written back its
    // count, so a count read never overlaps a pending write to the same entry.
    always_comb
    begin
        state_next   = state_reg;
        in_use_next  = in_use_reg;
        scan_next    = scan_reg;
        idx_next     = idx_reg;
        func_next    = func_reg;
        id_next      = id_reg;
        word_next    = word_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        fill_we      = 1'b0;
        fill_waddr   = idx_reg;
        fill_wdata   = fill_rdata;
        elem_we      = 1'b0;

        // Output register drains independently of the sequencer.
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_func;
                    id_next   = in_id;
                    word_next = in_word;
                    idx_next  = in_idx;
                    scan_next = '0;
                    res_next  = '{elem_count: '0, pop_word: '0, result_id: in_id, status: ST_OK};
                    if (in_func == FUNC_CREATE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (in_func > FUNC_COUNT || !in_used)
                    begin
                        res_next.status = ST_BAD;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
            end

            // Look for the lowest free handle, one per cycle.
            S_SCAN:
            begin
                if (!in_use_reg[scan_reg])
                begin
                    in_use_next[scan_reg] = 1'b1;
                    fill_we            = 1'b1;
                    fill_waddr         = scan_reg;
                    fill_wdata         = '0;
                    res_next.result_id = ID_BITS'({1'b0, scan_reg} + {{SW{1'b0}}, 1'b1});
                    state_next         = S_OUT;
                end
                else if (scan_reg == SW'(NUM_STACKS - 1))
                begin
                    res_next.status    = ST_NO_FREE;
                    res_next.result_id = '0;
                    state_next         = S_OUT;
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end

            // Count is on the read port: modify and write back.
            S_FILL:
            begin
                state_next = S_OUT;
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (fill_rdata == CW'(STACK_DEPTH))
                        begin
                            res_next.status     = ST_FULL;
                            res_next.elem_count = COUNT_BITS'(fill_rdata);
                        end
                        else
                        begin
                            elem_we             = 1'b1;
                            fill_we             = 1'b1;
                            fill_wdata          = fill_rdata + CW'(1);
                            res_next.elem_count = COUNT_BITS'(fill_rdata + CW'(1));
                        end
                    end
                    FUNC_POP:
                    begin
                        if (fill_rdata == '0)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            fill_we             = 1'b1;
                            fill_wdata          = fill_dec;
                            res_next.elem_count = COUNT_BITS'(fill_dec);
                            state_next          = S_POP;
                        end
                    end
                    FUNC_DESTROY:
                    begin
                        in_use_next[idx_reg] = 1'b0;
                        fill_we              = 1'b1;
                        fill_wdata           = '0;
                    end
                    default:
                    begin
                        res_next.elem_count = COUNT_BITS'(fill_rdata);
                    end
                endcase
            end

            // Popped word is on the element read port.
            S_POP:
            begin
                res_next.pop_word = pop_ext[DWORD_BITS-1:0];
                state_next        = S_OUT;
            end

            // Hand the result to the output register once it is free.
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        idx_reg    <= idx_next;
        func_reg   <= func_next;
        id_reg     <= id_next;
        word_reg   <= word_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // A request that reaches the count memory names a stack in use.
    `HMS_ASSERT_NOW(a_fill_in_use, clk, rst_n, state_reg == S_FILL, in_use_reg[idx_reg])
    // An element is written only below the stack's depth.
    `HMS_ASSERT_NOW(a_push_bound, clk, rst_n, elem_we, fill_rdata < CW'(STACK_DEPTH))
    // An element read follows a count read.
    `HMS_ASSERT_NOW(a_pop_order, clk, rst_n, state_reg == S_POP, $past(state_reg) == S_FILL)
    // An accepted item keeps the sequencer busy in the next cycle.
    `HMS_ASSERT_NEXT(a_one_item, clk, rst_n, accept, state_reg != S_IDLE)
    // The result id of a request other than create is the addressed handle.
    `HMS_ASSERT_NOW(a_res_id, clk, rst_n, state_reg == S_OUT && func_reg != FUNC_CREATE,
        res_reg.result_id == id_reg)

endmodule
